>>> hdl/spt_pkg.sv
// Shared types, constants and saturation helpers for the sparse polynomial term table.
// Used by the term RAM, the Q32.16 multiply unit and the top level.
package spt_pkg;

    localparam int MAX_TERMS = 16;
    localparam int MAX_EXP   = 255;
    localparam int ADDR_W    = $clog2(MAX_TERMS);
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int COEF_W    = 32;
    localparam int EXP_W     = 8;
    localparam int VAL_W     = 48;

    typedef enum logic [2:0] {
        FN_SET   = 3'd0,
        FN_ACC   = 3'd1,
        FN_EVAL  = 3'd2,
        FN_DERIV = 3'd3,
        FN_READ  = 3'd4,
        FN_CLEAR = 3'd5
    } t_func;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic        [EXP_W-1:0]  expo;
    } t_entry;

    function automatic logic signed [COEF_W-1:0] clamp32(input logic signed [63:0] v);
        logic signed [COEF_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp48(input logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'sd140737488355327) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -64'sd140737488355328) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/sparse_polynomial_term_table.sv
// Sparse polynomial term table: sequencer around the term RAM and the multiply unit.
// Depends on spt_pkg, spt_ram and spt_mulq.
//
// Usage: one item on the slave stream selects an operation by tuser (set term,
// accumulate term, evaluate, derivative, read out, clear); tdata carries coef,
// exponent and point. Each item yields one result on the master stream, except
// read out, which yields one result per stored term (one if empty) with tlast on the final one.
// One item is handled at a time; tready is high only while the sequencer idles.
// Per item, set/accumulate search the sorted terms and then, to delete or insert
// a term, move the terms behind it; evaluate runs Horner with one multiply per
// unit of the leading exponent; derivative rewrites the terms in place and drops
// the constant term; read out reads each term. The term RAM gives one read and one
// write per cycle with registered read data; each multiply goes through the
// 3-stage multiply pipeline.
// Results sit in an output register; a stalled receiver holds the sequencer at
// its next result while tready on the slave side stays low until done.
// Reset empties the table at once; the RAM contents need no clearing.
module sparse_polynomial_term_table
    import spt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // coef[31:0], exponent[39:32], point[71:40]
    input  logic [2:0]  i_s_axis_tuser,  // func[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,  // status[0], term_coef[32:1], term_exp[40:33],
                                         // value[88:41], term_count[93:89], zero[95:94]
    output logic        o_m_axis_tlast   // last
);

    typedef enum logic [4:0] {
        S_IDLE, S_SC_RD, S_SC_CHK, S_DEL_RD, S_DEL_WR, S_INS_RD, S_INS_WR,
        S_EV_RD0, S_EV_FIRST, S_EV_NEXT, S_EV_LOAD, S_EV_MUL, S_EV_WAIT,
        S_DRV_RD, S_DRV_MUL, S_DRV_WR, S_RO_RD, S_RO_DATA, S_EMIT
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count, r_i, r_j, r_p, r_n;
    logic [2:0]               r_func;
    logic signed [COEF_W-1:0] r_coef, r_x, r_cur;
    logic [EXP_W-1:0]         r_exp, r_prev, r_k, r_dexp;
    logic signed [VAL_W-1:0]  r_acc, r_value;
    logic                     r_status, r_tail;
    logic signed [40:0]       r_prod;

    logic                     r_out_valid, r_out_status, r_out_last;
    logic signed [COEF_W-1:0] r_out_coef;
    logic [EXP_W-1:0]         r_out_exp;
    logic signed [VAL_W-1:0]  r_out_value;
    logic [CNT_W-1:0]         r_out_count;

    logic                     w_we, w_re, w_out_free, w_mul_start, w_mul_done;
    logic [ADDR_W-1:0]        w_waddr, w_raddr;
    t_entry                   w_wdata, w_rdata;
    logic signed [VAL_W-1:0]  w_mul_res;
    logic signed [COEF_W-1:0] w_nc;
    logic [CNT_W-1:0]         w_jp1, w_jm1;
    logic                     w_insert_ok;

    spt_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    spt_mulq u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_acc    (r_acc),
        .i_x      (r_x),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_jp1       = r_j + 1'b1;
    assign w_jm1       = r_j - 1'b1;
    assign w_nc        = (r_func == FN_SET) ? r_coef
                                            : clamp32(64'(w_rdata.coef) + 64'(r_coef));
    assign w_insert_ok = (r_coef != '0) && (r_count < CNT_W'(MAX_TERMS));
    assign w_mul_start = (r_state == S_EV_MUL) && (r_k != '0);

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_i[ADDR_W-1:0];
        w_we    = 1'b0;
        w_waddr = r_j[ADDR_W-1:0];
        w_wdata = w_rdata;
        unique case (r_state)
            S_SC_RD:   w_re = (r_i != r_count);
            S_SC_CHK: begin
                if (w_rdata.expo == r_exp && w_nc != '0) begin
                    w_we    = 1'b1;
                    w_waddr = r_i[ADDR_W-1:0];
                    w_wdata = '{coef: w_nc, expo: r_exp};
                end
            end
            S_DEL_RD: begin
                w_re    = (w_jp1 < r_count);
                w_raddr = w_jp1[ADDR_W-1:0];
            end
            S_DEL_WR:  w_we = 1'b1;
            S_INS_RD: begin
                w_re    = (r_j > r_p);
                w_raddr = w_jm1[ADDR_W-1:0];
                if (r_j == r_p) begin
                    w_we    = 1'b1;
                    w_waddr = r_p[ADDR_W-1:0];
                    w_wdata = '{coef: r_coef, expo: r_exp};
                end
            end
            S_INS_WR:  w_we = 1'b1;
            S_EV_RD0: begin
                w_re    = (r_count != '0);
                w_raddr = '0;
            end
            S_EV_NEXT: w_re = (r_i < r_count);
            S_DRV_RD:  w_re = (r_i < r_count);
            S_DRV_WR: begin
                w_we    = 1'b1;
                w_waddr = r_n[ADDR_W-1:0];
                w_wdata = '{coef: clamp32(64'(r_prod)), expo: r_dexp};
            end
            S_RO_RD:   w_re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the emitting states reload the output register themselves
            if (r_out_valid && i_m_axis_tready &&
                !((r_state == S_EMIT) || (r_state == S_RO_DATA))) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_func   <= i_s_axis_tuser;
                        r_coef   <= $signed(i_s_axis_tdata[31:0]);
                        r_exp    <= i_s_axis_tdata[39:32];
                        r_x      <= $signed(i_s_axis_tdata[71:40]);
                        r_status <= 1'b0;
                        r_value  <= '0;
                        r_i      <= '0;
                        r_n      <= '0;
                        unique case (i_s_axis_tuser)
                            FN_SET, FN_ACC: begin
                                r_state <= (int'(i_s_axis_tdata[39:32]) <= MAX_EXP)
                                           ? S_SC_RD : S_EMIT;
                            end
                            FN_EVAL:  r_state <= S_EV_RD0;
                            FN_DERIV: r_state <= S_DRV_RD;
                            FN_READ:  r_state <= (r_count == '0) ? S_EMIT : S_RO_RD;
                            FN_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_EMIT;
                            end
                            default:  r_state <= S_EMIT;
                        endcase
                    end
                end
                S_SC_RD: begin
                    if (r_i == r_count) begin
                        r_p <= r_count;
                        r_j <= r_count;
                        if (!w_insert_ok) begin
                            r_status <= (r_coef != '0);
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_INS_RD;
                        end
                    end else begin
                        r_state <= S_SC_CHK;
                    end
                end
                S_SC_CHK: begin
                    if (w_rdata.expo == r_exp) begin
                        r_j     <= r_i;
                        r_state <= (w_nc == '0) ? S_DEL_RD : S_EMIT;
                    end else if (w_rdata.expo < r_exp) begin
                        // sorted place found, no matching term
                        r_p <= r_i;
                        r_j <= r_count;
                        if (!w_insert_ok) begin
                            r_status <= (r_coef != '0);
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_INS_RD;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SC_RD;
                    end
                end
                S_DEL_RD: begin
                    if (w_jp1 < r_count) begin
                        r_state <= S_DEL_WR;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_DEL_WR: begin
                    r_j     <= w_jp1;
                    r_state <= S_DEL_RD;
                end
                S_INS_RD: begin
                    if (r_j > r_p) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_INS_WR: begin
                    r_j     <= w_jm1;
                    r_state <= S_INS_RD;
                end
                S_EV_RD0: begin
                    r_state <= (r_count == '0) ? S_EMIT : S_EV_FIRST;
                end
                S_EV_FIRST: begin
                    r_acc   <= VAL_W'(w_rdata.coef);
                    r_prev  <= w_rdata.expo;
                    r_i     <= CNT_W'(1);
                    r_tail  <= 1'b0;
                    r_state <= S_EV_NEXT;
                end
                S_EV_NEXT: begin
                    if (r_i < r_count) begin
                        r_state <= S_EV_LOAD;
                    end else begin
                        r_k     <= r_prev;
                        r_tail  <= 1'b1;
                        r_state <= S_EV_MUL;
                    end
                end
                S_EV_LOAD: begin
                    r_k     <= r_prev - w_rdata.expo;
                    r_cur   <= w_rdata.coef;
                    r_prev  <= w_rdata.expo;
                    r_state <= S_EV_MUL;
                end
                S_EV_MUL: begin
                    if (r_k != '0) begin
                        r_state <= S_EV_WAIT;
                    end else if (r_tail) begin
                        r_value <= r_acc;
                        r_state <= S_EMIT;
                    end else begin
                        r_acc   <= clamp48(64'(r_acc) + 64'(r_cur));
                        r_i     <= r_i + 1'b1;
                        r_state <= S_EV_NEXT;
                    end
                end
                S_EV_WAIT: begin
                    if (w_mul_done) begin
                        r_acc   <= w_mul_res;
                        r_k     <= r_k - 1'b1;
                        r_state <= S_EV_MUL;
                    end
                end
                S_DRV_RD: begin
                    if (r_i < r_count) begin
                        r_state <= S_DRV_MUL;
                    end else begin
                        r_count <= r_n;
                        r_state <= S_EMIT;
                    end
                end
                S_DRV_MUL: begin
                    if (w_rdata.expo != '0) begin
                        r_prod  <= w_rdata.coef * $signed({1'b0, w_rdata.expo});
                        r_dexp  <= w_rdata.expo - 1'b1;
                        r_state <= S_DRV_WR;
                    end else begin
                        // constant term dropped
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DRV_RD;
                    end
                end
                S_DRV_WR: begin
                    r_n     <= r_n + 1'b1;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_DRV_RD;
                end
                S_RO_RD: r_state <= S_RO_DATA;
                S_RO_DATA: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= 1'b0;
                        r_out_coef   <= w_rdata.coef;
                        r_out_exp    <= w_rdata.expo;
                        r_out_value  <= '0;
                        r_out_count  <= r_count;
                        r_out_last   <= (r_i + 1'b1 == r_count);
                        r_i          <= r_i + 1'b1;
                        r_state      <= (r_i + 1'b1 == r_count) ? S_IDLE : S_RO_RD;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_coef   <= '0;
                        r_out_exp    <= '0;
                        r_out_value  <= r_value;
                        r_out_count  <= r_count;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {2'b00, r_out_count, r_out_value, r_out_exp, r_out_coef,
                              r_out_status};

endmodule

>>> hdl/spt_ram.sv
// Term store: one write port, one read port, registered read data.
// Depends on spt_pkg for the entry type and depth.
module spt_ram
    import spt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [MAX_TERMS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/spt_mulq.sv
// Three-stage Q32.16 by Q16.16 multiply, rounded half away from zero, saturated to 48 bits.
// Depends on spt_pkg for widths.
module spt_mulq
    import spt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [VAL_W-1:0] i_acc,
    input  logic signed [COEF_W-1:0] i_x,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_result
);

    logic                    r_v1, r_v2, r_v3;
    logic                    r_neg1, r_neg2;
    logic [VAL_W-1:0]        r_ua;
    logic [COEF_W-1:0]       r_ux;
    logic [63:0]             r_phi;
    logic [VAL_W-1:0]        r_plo;
    logic signed [VAL_W-1:0] r_res;
    logic [63:0]             w_mag;

    assign w_mag = r_phi + 64'((r_plo + 48'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        // magnitudes and sign
        r_neg1 <= i_acc[VAL_W-1] ^ i_x[COEF_W-1];
        r_ua   <= i_acc[VAL_W-1] ? VAL_W'(-i_acc) : VAL_W'(i_acc);
        r_ux   <= i_x[COEF_W-1] ? COEF_W'(-i_x) : COEF_W'(i_x);
        // partial products
        r_neg2 <= r_neg1;
        r_phi  <= 64'(r_ua[VAL_W-1:16]) * 64'(r_ux);
        r_plo  <= VAL_W'(r_ua[15:0]) * VAL_W'(r_ux);
        // combine and saturate
        if (r_neg2) begin
            if (w_mag >= 64'h0000_8000_0000_0000) begin
                r_res <= 48'sh8000_0000_0000;
            end else begin
                r_res <= -$signed(w_mag[VAL_W-1:0]);
            end
        end else begin
            if (w_mag > 64'h0000_7FFF_FFFF_FFFF) begin
                r_res <= 48'sh7FFF_FFFF_FFFF;
            end else begin
                r_res <= $signed(w_mag[VAL_W-1:0]);
            end
        end
    end

    assign o_done   = r_v3;
    assign o_result = r_res;

endmodule

>>> tb/sparse_polynomial_term_table_chk.sv
// Checker for the sparse polynomial term table: watches both streams, keeps its own
// copy of the term list and compares every result item. Depends on spt_pkg.
module sparse_polynomial_term_table_chk
    import spt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,
    input  logic [2:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_fail_cnt,
    output int          o_pending
);

    typedef struct packed {
        logic              status;
        logic signed [31:0] tcoef;
        logic [7:0]        texp;
        logic signed [47:0] val;
        logic [4:0]        cnt;
        logic              lst;
    } t_res;

    localparam logic signed [63:0] MAX48 = 64'sd140737488355327;
    localparam logic signed [63:0] MIN48 = -64'sd140737488355328;

    logic signed [31:0] m_coef [MAX_TERMS];
    logic [7:0]         m_exp  [MAX_TERMS];
    int                 m_cnt;
    t_res               res_q[$];
    int                 fails;

    assign o_fail_cnt = fails;
    assign o_pending  = res_q.size();

    function automatic logic signed [63:0] sat48(input logic signed [63:0] v);
        if (v > MAX48) return MAX48;
        if (v < MIN48) return MIN48;
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Q32.16 times Q16.16, rounded to nearest with ties away from zero
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] x);
        logic neg;
        logic [63:0] ua, ux, mag;
        if (a == 0 || x == 0) return 0;
        neg = (a < 0) != (x < 0);
        ua = a < 0 ? -a : a;
        ux = x < 0 ? -x : x;
        mag = (ua >> 16) * ux + (((ua & 64'hFFFF) * ux + 64'h8000) >> 16);
        if (neg) return (mag >= 64'd140737488355328) ? MIN48 : -$signed(mag);
        return (mag > 64'd140737488355327) ? MAX48 : $signed(mag);
    endfunction

    function automatic logic signed [63:0] horner(input logic signed [63:0] x);
        logic signed [63:0] acc;
        if (m_cnt == 0) return 0;
        acc = m_coef[0];
        for (int i = 1; i < m_cnt; i++) begin
            for (int k = m_exp[i]; k < m_exp[i-1]; k++) acc = qmul(acc, x);
            acc = sat48(acc + m_coef[i]);
        end
        for (int k = 0; k < m_exp[m_cnt-1]; k++) acc = qmul(acc, x);
        return acc;
    endfunction

    task automatic predict_terms(input logic [2:0] fn, input logic signed [31:0] c,
                                 input logic [7:0] e, input logic signed [31:0] x);
        t_res r;
        int idx, p, n;
        logic signed [31:0] nc;
        r = '0;
        r.lst = 1'b1;
        if (fn == FN_READ && m_cnt > 0) begin
            for (int i = 0; i < m_cnt; i++) begin
                r.tcoef = m_coef[i];
                r.texp  = m_exp[i];
                r.cnt   = 5'(m_cnt);
                r.lst   = (i == m_cnt - 1);
                res_q.push_back(r);
            end
            return;
        end
        if (fn == FN_SET || fn == FN_ACC) begin
            idx = -1;
            for (int i = 0; i < m_cnt; i++) if (m_exp[i] == e && idx < 0) idx = i;
            if (idx >= 0) begin
                nc = (fn == FN_SET) ? c : sat32(64'(m_coef[idx]) + 64'(c));
                if (nc == 0) begin
                    for (int i = idx; i + 1 < m_cnt; i++) begin
                        m_coef[i] = m_coef[i+1];
                        m_exp[i]  = m_exp[i+1];
                    end
                    m_cnt--;
                end else m_coef[idx] = nc;
            end else if (c != 0) begin
                if (m_cnt >= MAX_TERMS) r.status = 1'b1;
                else begin
                    p = 0;
                    while (p < m_cnt && m_exp[p] > e) p++;
                    for (int i = m_cnt; i > p; i--) begin
                        m_coef[i] = m_coef[i-1];
                        m_exp[i]  = m_exp[i-1];
                    end
                    m_coef[p] = c;
                    m_exp[p]  = e;
                    m_cnt++;
                end
            end
        end else if (fn == FN_EVAL) begin
            r.val = 48'(horner(64'(x)));
        end else if (fn == FN_DERIV) begin
            n = 0;
            for (int i = 0; i < m_cnt; i++) begin
                if (m_exp[i] != 0) begin
                    m_coef[n] = sat32(64'(m_coef[i]) * 64'(m_exp[i]));
                    m_exp[n]  = m_exp[i] - 8'd1;
                    n++;
                end
            end
            m_cnt = n;
        end else if (fn == FN_CLEAR) begin
            m_cnt = 0;
        end
        r.cnt = 5'(m_cnt);
        res_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            m_cnt = 0;
            fails = 0;
            res_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[0], i_m_tdata[32:1], i_m_tdata[40:33], i_m_tdata[88:41],
                       i_m_tdata[93:89], i_m_tlast};
                if (res_q.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, got);
                    fails++;
                end else begin
                    want = res_q.pop_front();
                    if (got.status != want.status || got.tcoef != want.tcoef ||
                        got.texp != want.texp || got.val != want.val ||
                        got.cnt != want.cnt || got.lst != want.lst ||
                        i_m_tdata[95:94] != 2'b00) begin
                        $display("%0t: mismatch exp st=%0d c=%h e=%0d v=%h n=%0d l=%0d",
                                 $time, want.status, want.tcoef, want.texp, want.val,
                                 want.cnt, want.lst);
                        $display("%0t:          got st=%0d c=%h e=%0d v=%h n=%0d l=%0d",
                                 $time, got.status, got.tcoef, got.texp, got.val,
                                 got.cnt, got.lst);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_terms(i_s_tuser, i_s_tdata[31:0], i_s_tdata[39:32], i_s_tdata[71:40]);
        end
    end

endmodule

>>> tb/sparse_polynomial_term_table_tb.sv
// Top of the term table testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on spt_pkg, the block and sparse_polynomial_term_table_chk.
module sparse_polynomial_term_table_tb;
    import spt_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tlast;
    int          fail_cnt, pending, idle_cycles;
    logic [7:0]  exp_pool [6] = '{8'd0, 8'd1, 8'd2, 8'd5, 8'd7, 8'd255};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sparse_polynomial_term_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tlast(m_tlast)
    );

    sparse_polynomial_term_table_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tlast(m_tlast),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    // receiver stalls: random wait per item, some stretches without
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            @(negedge i_clk);
            m_tready <= 1'b0;
            repeat (gap) @(negedge i_clk);
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_op(input logic [2:0] fn, input logic [31:0] c,
                           input logic [7:0] e, input logic [31:0] x);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {x, e, c};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
            3: return 32'(int'($urandom_range(0, 8)) - 4) <<< 16;
            default: return $urandom();
        endcase
    endfunction

    // points within +-0.75 keep the Horner chain from saturating at once
    function automatic logic [31:0] rand_point();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'h0;
            default: return 32'(int'($urandom_range(0, 98304)) - 49152);
        endcase
    endfunction

    initial begin
        logic [2:0] fn;
        int r;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty read, extremes, fill past capacity, delete, derivative
        send_op(FN_READ, 0, 0, 0);
        send_op(FN_EVAL, 0, 0, 32'h00010000);
        send_op(FN_SET, 32'h7FFFFFFF, 8'd255, 0);
        send_op(FN_SET, 32'h80000000, 8'd0, 0);
        send_op(FN_SET, 0, 8'd9, 0);
        send_op(FN_ACC, 32'h7FFFFFFF, 8'd255, 0);
        send_op(FN_ACC, 32'h7FFFFFFF, 8'd0, 0);
        send_op(FN_EVAL, 0, 0, 32'hFFFFFFFF);
        send_op(FN_EVAL, 0, 0, 32'h80000000);
        for (int i = 1; i <= 15; i++) send_op(FN_SET, 32'h00010000 * i, 8'(i * 3), 0);
        send_op(FN_SET, 32'h00020000, 8'd200, 0);
        send_op(FN_READ, 0, 0, 0);
        send_op(FN_SET, 0, 8'd255, 0);
        send_op(FN_ACC, 32'hFFF10000, 8'd45, 0);
        send_op(FN_DERIV, 0, 0, 0);
        send_op(FN_READ, 0, 0, 0);
        send_op(3'd6, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF);
        send_op(3'd7, 0, 0, 0);
        send_op(FN_CLEAR, 0, 0, 0);

        // hold off until the block has drained
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        for (int n = 0; n < 88; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) fn = FN_SET;
            else if (r < 65) fn = FN_ACC;
            else if (r < 78) fn = FN_EVAL;
            else if (r < 85) fn = FN_DERIV;
            else if (r < 94) fn = FN_READ;
            else if (r < 97) fn = FN_CLEAR;
            else fn = 3'($urandom_range(6, 7));
            send_op(fn, ($urandom_range(0, 9) == 0) ? 32'h0 : rand_coef(),
                    ($urandom_range(0, 4) == 0) ? 8'($urandom()) :
                        exp_pool[$urandom_range(0, 5)] + 8'($urandom_range(0, 3)),
                    rand_point());
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_cnt == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
